// ===== rtl/vad_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the vector angle block.
// Used by vad_isqrt and vector_angle_degrees_top; depends on nothing else.
package vad_pkg;

  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned OUT_W        = 24;
  localparam int unsigned CORDIC_ITERS = 30;
  localparam int unsigned SQRT_STAGES  = 31;
  localparam int unsigned SQRT_W       = 2 * SQRT_STAGES;
  localparam int unsigned CW           = 34;

  localparam logic [30:0] ONE_Q30     = 31'd1073741824;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] RAD2DEG_Q26 = 32'd3845054675;

  localparam logic [CW-1:0] ARC_TAB [10] = '{
    34'd843314857, 34'd497837829, 34'd263043837, 34'd133525159, 34'd67021687,
    34'd33543516, 34'd16775851, 34'd8388437, 34'd4194283, 34'd2097149
  };

  typedef struct packed {
    logic       vld;
    logic       degen;
    logic [2:0] neg;
    logic       dneg;
  } side_t;

  function automatic logic [CW-1:0] arc_step(input int unsigned i);
    if (i < 10) begin
      return ARC_TAB[i];
    end
    return CW'(1) << (30 - i);
  endfunction

  function automatic logic [4:0] msb_pos(input logic [31:0] m);
    logic [4:0] p;
    p = '0;
    for (int b = 0; b < 32; b++) begin
      if (m[b]) begin
        p = 5'(b);
      end
    end
    return p;
  endfunction

endpackage

// ===== rtl/vad_isqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per register stage.
// Depends on vad_pkg for the radicand width and the stage count.
module vad_isqrt (
  input  logic                               clk_i,
  input  logic [vad_pkg::SQRT_W-1:0]         rad_i,
  output logic [vad_pkg::SQRT_STAGES-1:0]    root_o
);
  import vad_pkg::*;

  localparam int unsigned RW = SQRT_STAGES + 4;

  logic [SQRT_W-1:0]      rad_q  [SQRT_STAGES-1];
  logic [RW-1:0]          rem_q  [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] root_q [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic [SQRT_W-1:0]      rad_in;
    logic [RW-1:0]          rem_in;
    logic [RW-1:0]          rem_sh;
    logic [RW-1:0]          trial;
    logic [SQRT_STAGES-1:0] root_in;

    if (s == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    assign rem_sh = {rem_in[RW-3:0], rad_in[SQRT_W-1 -: 2]};
    assign trial  = {{(RW-SQRT_STAGES-2){1'b0}}, root_in, 2'b01};

    if (s < SQRT_STAGES - 1) begin : g_rad
      always_ff @(posedge clk_i) begin
        rad_q[s] <= {rad_in[SQRT_W-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i) begin
      if (rem_sh >= trial) begin
        rem_q[s]  <= rem_sh - trial;
        root_q[s] <= {root_in[SQRT_STAGES-2:0], 1'b1};
      end else begin
        rem_q[s]  <= rem_sh;
        root_q[s] <= {root_in[SQRT_STAGES-2:0], 1'b0};
      end
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];

endmodule

// ===== rtl/vector_angle_degrees_top.sv =====
`timescale 1ns / 1ps
// Angle between two 3D vectors in degrees, fully pipelined.
// Depends on vad_pkg and vad_isqrt.
//
//  channel | ports                                            | handshake
//  --------+--------------------------------------------------+-----------------------
//  input   | first_x/y/z_i, second_x/y/z_i (signed Q15.16)    | start_i while !busy_o
//  result  | angle_deg_o, supplement_deg_o, degenerate_o      | done_o strobe, 1 cycle
//
// A new item is taken in every cycle. The pipeline runs through two square
// roots in parallel, the division, a third square root and the CORDIC arc,
// each one bit or one step per stage. busy_o is always low and the pipeline
// never stalls. Reset clears only the side fields (valid, degenerate and sign
// flags) that travel with the items.
module vector_angle_degrees_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic signed [31:0]          first_x_i,
  input  logic signed [31:0]          first_y_i,
  input  logic signed [31:0]          first_z_i,
  input  logic signed [31:0]          second_x_i,
  input  logic signed [31:0]          second_y_i,
  input  logic signed [31:0]          second_z_i,
  output logic                        done_o,
  output logic [vad_pkg::OUT_W-1:0]   angle_deg_o,
  output logic [vad_pkg::OUT_W-1:0]   supplement_deg_o,
  output logic                        degenerate_o
);
  import vad_pkg::*;

  localparam int unsigned LAT   = 135;
  localparam int unsigned S_AD  = 6;
  localparam int unsigned S_P   = 37;
  localparam int unsigned S_Q   = 69;
  localparam int unsigned S_SN  = 102;
  localparam int unsigned DIV_N = 30;
  localparam logic [64:0] FULL  = 65'(180) << FRAC_BITS;
  localparam logic [64:0] RND   = 65'(1) << (55 - FRAC_BITS);

  side_t side_q  [1:LAT];
  side_t side_nx [1:LAT];

  logic [31:0] in_a [3];
  logic [31:0] in_b [3];
  logic [31:0] ma_q [3];
  logic [31:0] mb_q [3];
  logic [31:0] ma2_q [3];
  logic [31:0] mb2_q [3];
  logic [4:0]  pa_q, pb_q;
  logic [28:0] sa_q [3];
  logic [28:0] sb_q [3];
  logic [57:0] pd_q [3];
  logic [57:0] pn_q [3];
  logic [57:0] pm_q [3];
  logic signed [60:0] d_q;
  logic signed [60:0] dsum;
  logic [59:0] na_q, nb_q;
  logic [59:0] ad_q [S_AD:S_P];
  logic [SQRT_STAGES-1:0] root_a, root_b, root_c;
  logic [59:0] p_q;
  logic [60:0] dr_q  [DIV_N+1];
  logic [59:0] dpv_q [DIV_N+1];
  logic        dsat_q [DIV_N+1];
  logic [29:0] dq_q  [DIV_N+1];
  logic [30:0] qd_q  [S_Q:S_SN];
  logic [61:0] qq_q;
  logic [61:0] rad2_q;
  logic signed [CW-1:0] cx_q [CORDIC_ITERS];
  logic signed [CW-1:0] cy_q [CORDIC_ITERS];
  logic signed [CW-1:0] cz_q [CORDIC_ITERS];
  logic signed [CW-1:0] ang_s;
  logic [31:0] ang_q;
  logic [63:0] prod_q;
  logic [64:0] deg_s;
  logic [64:0] deg_c;
  logic [OUT_W-1:0] angle_q, supp_q;
  logic        degen_q;

  assign busy_o = 1'b0;

  assign in_a = '{first_x_i, first_y_i, first_z_i};
  assign in_b = '{second_x_i, second_y_i, second_z_i};

  always_comb begin
    for (int k = 2; k <= LAT; k++) begin
      side_nx[k] = side_q[k-1];
    end
    side_nx[1].vld   = start_i & ~busy_o;
    side_nx[1].degen = 1'b0;
    side_nx[1].dneg  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      side_nx[1].neg[i] = in_a[i][31] ^ in_b[i][31];
    end
    side_nx[2].degen = ((ma_q[0] | ma_q[1] | ma_q[2]) == '0) ||
                       ((mb_q[0] | mb_q[1] | mb_q[2]) == '0);
    side_nx[S_AD].dneg = d_q[60];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= LAT; k++) begin
        side_q[k] <= '0;
      end
    end else begin
      for (int k = 1; k <= LAT; k++) begin
        side_q[k] <= side_nx[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      ma_q[i]  <= in_a[i][31] ? (32'd0 - in_a[i]) : in_a[i];
      mb_q[i]  <= in_b[i][31] ? (32'd0 - in_b[i]) : in_b[i];
      ma2_q[i] <= ma_q[i];
      mb2_q[i] <= mb_q[i];
      sa_q[i]  <= (pa_q > 5'd28) ? 29'(ma2_q[i] >> (pa_q - 5'd28))
                                 : 29'(ma2_q[i] << (5'd28 - pa_q));
      sb_q[i]  <= (pb_q > 5'd28) ? 29'(mb2_q[i] >> (pb_q - 5'd28))
                                 : 29'(mb2_q[i] << (5'd28 - pb_q));
      pd_q[i]  <= 58'(sa_q[i]) * 58'(sb_q[i]);
      pn_q[i]  <= 58'(sa_q[i]) * 58'(sa_q[i]);
      pm_q[i]  <= 58'(sb_q[i]) * 58'(sb_q[i]);
    end
    pa_q <= msb_pos(ma_q[0] | ma_q[1] | ma_q[2]);
    pb_q <= msb_pos(mb_q[0] | mb_q[1] | mb_q[2]);
  end

  always_comb begin
    dsum = '0;
    for (int i = 0; i < 3; i++) begin
      if (side_q[4].neg[i]) begin
        dsum = dsum - $signed(61'(pd_q[i]));
      end else begin
        dsum = dsum + $signed(61'(pd_q[i]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d_q  <= dsum;
    na_q <= 60'(pn_q[0]) + 60'(pn_q[1]) + 60'(pn_q[2]);
    nb_q <= 60'(pm_q[0]) + 60'(pm_q[1]) + 60'(pm_q[2]);
    ad_q[S_AD] <= d_q[60] ? 60'(-d_q) : 60'(d_q);
    for (int k = S_AD + 1; k <= S_P; k++) begin
      ad_q[k] <= ad_q[k-1];
    end
  end

  vad_isqrt u_sqrt_a (
    .clk_i  (clk_i),
    .rad_i  ({2'b00, na_q}),
    .root_o (root_a)
  );

  vad_isqrt u_sqrt_b (
    .clk_i  (clk_i),
    .rad_i  ({2'b00, nb_q}),
    .root_o (root_b)
  );

  always_ff @(posedge clk_i) begin
    p_q       <= 60'(62'(root_a) * 62'(root_b));
    dr_q[0]   <= 61'(ad_q[S_P]);
    dpv_q[0]  <= p_q;
    dsat_q[0] <= ad_q[S_P] >= p_q;
    dq_q[0]   <= '0;
  end

  for (genvar j = 1; j <= DIV_N; j++) begin : g_div
    logic [60:0] rs;
    assign rs = {dr_q[j-1][59:0], 1'b0};
    always_ff @(posedge clk_i) begin
      dpv_q[j]  <= dpv_q[j-1];
      dsat_q[j] <= dsat_q[j-1];
      if (rs >= 61'(dpv_q[j-1])) begin
        dr_q[j] <= rs - 61'(dpv_q[j-1]);
        dq_q[j] <= {dq_q[j-1][28:0], 1'b1};
      end else begin
        dr_q[j] <= rs;
        dq_q[j] <= {dq_q[j-1][28:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qd_q[S_Q] <= dsat_q[DIV_N] ? ONE_Q30 : {1'b0, dq_q[DIV_N]};
    for (int k = S_Q + 1; k <= S_SN; k++) begin
      qd_q[k] <= qd_q[k-1];
    end
    qq_q   <= 62'(qd_q[S_Q]) * 62'(qd_q[S_Q]);
    rad2_q <= (62'(1) << 60) - qq_q;
  end

  vad_isqrt u_sqrt_c (
    .clk_i  (clk_i),
    .rad_i  (rad2_q),
    .root_o (root_c)
  );

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cordic
    logic signed [CW-1:0] x_in, y_in, z_in, xs, ys;
    if (i == 0) begin : g_first
      assign x_in = $signed(CW'(qd_q[S_SN]));
      assign y_in = $signed(CW'(root_c));
      assign z_in = '0;
    end else begin : g_next
      assign x_in = cx_q[i-1];
      assign y_in = cy_q[i-1];
      assign z_in = cz_q[i-1];
    end
    assign xs = x_in >>> i;
    assign ys = y_in >>> i;
    always_ff @(posedge clk_i) begin
      if (!y_in[CW-1]) begin
        cx_q[i] <= x_in + ys;
        cy_q[i] <= y_in - xs;
        cz_q[i] <= z_in + $signed(arc_step(i));
      end else begin
        cx_q[i] <= x_in - ys;
        cy_q[i] <= y_in + xs;
        cz_q[i] <= z_in - $signed(arc_step(i));
      end
    end
  end

  assign ang_s = side_q[LAT-3].dneg ? ($signed(CW'(PI_Q30)) - cz_q[CORDIC_ITERS-1])
                                    : cz_q[CORDIC_ITERS-1];
  assign deg_s = (65'(prod_q) + RND) >> (56 - FRAC_BITS);
  assign deg_c = (deg_s > FULL) ? FULL : deg_s;

  always_ff @(posedge clk_i) begin
    if (ang_s[CW-1]) begin
      ang_q <= '0;
    end else if (ang_s > $signed(CW'(PI_Q30))) begin
      ang_q <= PI_Q30;
    end else begin
      ang_q <= 32'(ang_s);
    end
    prod_q  <= 64'(ang_q) * 64'(RAD2DEG_Q26);
    degen_q <= side_q[LAT-1].degen;
    if (side_q[LAT-1].degen) begin
      angle_q <= '0;
      supp_q  <= '0;
    end else begin
      angle_q <= OUT_W'(deg_c);
      supp_q  <= OUT_W'(FULL - deg_c);
    end
  end

  assign done_o           = side_q[LAT].vld;
  assign angle_deg_o      = angle_q;
  assign supplement_deg_o = supp_q;
  assign degenerate_o     = degen_q;

`ifndef ASSERT_OFF
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("Result strobe without a matching accepted item.");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |-> (angle_deg_o == '0 && supplement_deg_o == '0))
    else $error("Degenerate item with nonzero angles.");

  a_supplement: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !degenerate_o) |->
      (OUT_W'(angle_deg_o + supplement_deg_o) == OUT_W'(FULL)))
    else $error("Angle and supplement do not add up to a half turn.");
`endif

endmodule

// ===== tb/tb_vector_angle_degrees_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for vector_angle_degrees_top: directed vectors, then random pairs.
// Depends on vad_pkg and the RTL of vector_angle_degrees_top; expected angles come from
// the table for known directed rows, else from a bit-exact integer predictor in this file.
module tb_vector_angle_degrees_top;
  import vad_pkg::*;

  localparam int unsigned N_RANDOM = 1700;
  localparam int unsigned LATENCY = 135;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [OUT_W-1:0] angle;
    logic [OUT_W-1:0] supp;
    logic             degen;
  } angle_res_t;

  typedef struct {
    logic [31:0] v [6];
    logic        known;
    angle_res_t  res;
  } vec_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [31:0] first_x_i = '0, first_y_i = '0, first_z_i = '0;
  logic signed [31:0] second_x_i = '0, second_y_i = '0, second_z_i = '0;
  logic done_o;
  logic [OUT_W-1:0] angle_deg_o, supplement_deg_o;
  logic degenerate_o;

  angle_res_t pending_angles [$];
  int unsigned error_count = 0;
  longint unsigned cycle_count = 0;
  vec_row_t dir_rows [$];

  vector_angle_degrees_top dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .first_x_i, .first_y_i, .first_z_i, .second_x_i, .second_y_i, .second_z_i,
    .done_o, .angle_deg_o, .supplement_deg_o, .degenerate_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic logic normalize(ref logic [63:0] m [3]);
    logic [63:0] mx;
    int rs, ls;
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    if (mx == 0) return 1'b0;
    rs = 0;
    ls = 0;
    while ((mx >> rs) >= (64'd1 << 29)) rs++;
    while ((mx << ls) < (64'd1 << 28)) ls++;
    for (int i = 0; i < 3; i++) m[i] = (m[i] >> rs) << ls;
    return 1'b1;
  endfunction

  function automatic angle_res_t predict_angle(input logic [31:0] v [6]);
    logic [63:0] ma [3], mb [3];
    logic sa [3], sb [3];
    logic [63:0] na, nb, p, ad, r, q, sn, deg, full, t;
    longint d, x, y, z, xs, ys, ang, stp;
    angle_res_t res;
    na = 0;
    nb = 0;
    d = 0;
    full = 64'd180 << FRAC_BITS;
    res = '{angle: '0, supp: '0, degen: 1'b1};
    for (int i = 0; i < 3; i++) begin
      sa[i] = v[i][31];
      sb[i] = v[i+3][31];
      ma[i] = sa[i] ? (64'd1 << 32) - v[i] : {32'd0, v[i]};
      mb[i] = sb[i] ? (64'd1 << 32) - v[i+3] : {32'd0, v[i+3]};
    end
    if (!normalize(ma) || !normalize(mb)) return res;
    for (int i = 0; i < 3; i++) begin
      t = ma[i] * mb[i];
      d = (sa[i] != sb[i]) ? d - longint'(t) : d + longint'(t);
      na += ma[i] * ma[i];
      nb += mb[i] * mb[i];
    end
    p = int_sqrt(na) * int_sqrt(nb);
    ad = d < 0 ? -d : d;
    if (ad >= p) begin
      q = 64'd1 << 30;
    end else begin
      r = ad;
      q = 0;
      for (int i = 0; i < 30; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= p) begin
          r -= p;
          q |= 1;
        end
      end
    end
    sn = int_sqrt((64'd1 << 60) - q * q);
    x = q;
    y = sn;
    z = 0;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      stp = longint'(arc_step(i));
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += stp;
      end else begin
        x -= ys; y += xs; z -= stp;
      end
    end
    ang = d < 0 ? longint'(PI_Q30) - z : z;
    if (ang < 0) ang = 0;
    if (ang > longint'(PI_Q30)) ang = PI_Q30;
    deg = (64'(ang) * 64'(RAD2DEG_Q26) + (64'd1 << (55 - FRAC_BITS))) >> (56 - FRAC_BITS);
    if (deg > full) deg = full;
    res.angle = deg[OUT_W-1:0];
    res.supp = OUT_W'(full - deg);
    res.degen = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("vector_angle_degrees_top: mismatch");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (pending_angles.size() == 0) begin
        report_mismatch("unexpected result, angle", angle_deg_o, 0);
      end else begin
        angle_res_t e;
        e = pending_angles.pop_front();
        if (angle_deg_o !== e.angle) report_mismatch("angle_deg", angle_deg_o, e.angle);
        if (supplement_deg_o !== e.supp)
          report_mismatch("supplement_deg", supplement_deg_o, e.supp);
        if (degenerate_o !== e.degen) report_mismatch("degenerate", degenerate_o, e.degen);
      end
    end
  end

  task automatic send_pair(input logic [31:0] v [6], input logic known, input angle_res_t r);
    angle_res_t e;
    e = predict_angle(v);
    if (known && (e.angle != r.angle || e.supp != r.supp || e.degen != r.degen))
      report_mismatch("predictor vs table, angle", e.angle, r.angle);
    first_x_i <= v[0]; first_y_i <= v[1]; first_z_i <= v[2];
    second_x_i <= v[3]; second_y_i <= v[4]; second_z_i <= v[5];
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_angles.push_back(known ? r : e);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_comp(input int kind);
    logic [31:0] w;
    w = $urandom;
    case (kind)
      0: return w;
      1: return 32'($signed(w) >>> $urandom_range(0, 31));
      2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'($signed(w[15:0]));
    endcase
  endfunction

  function automatic vec_row_t mk_row(input logic [31:0] a, b, c, d, e, f, input logic known,
                                      input int unsigned ang, input int unsigned sup,
                                      input logic dg);
    vec_row_t row;
    row.v = '{a, b, c, d, e, f};
    row.known = known;
    row.res = '{angle: ang[OUT_W-1:0], supp: sup[OUT_W-1:0], degen: dg};
    return row;
  endfunction

  initial begin
    logic [31:0] v [6];
    angle_res_t none;
    int kind;
    none = '{angle: '0, supp: '0, degen: 1'b0};
    dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 1));
    dir_rows.push_back(mk_row(0, 0, 0, 32'h10000, 0, 0, 1, 0, 0, 1));
    dir_rows.push_back(mk_row(32'h10000, 0, 0, 0, 0, 0, 1, 0, 0, 1));
    dir_rows.push_back(mk_row(32'h10000, 0, 0, 32'h10000, 0, 0, 1, 0, 180 << 16, 0));
    dir_rows.push_back(mk_row(32'h10000, 0, 0, 32'hffff0000, 0, 0, 1, 180 << 16, 0, 0));
    dir_rows.push_back(mk_row(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(32'h80000000, 32'h80000000, 32'h80000000,
                              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(32'h80000000, 32'h80000000, 32'h80000000,
                              32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(1, 0, 0, 32'h7fffffff, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(1, 1, 1, 32'hffffffff, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 1, 0, 0, 1));
    dir_rows.push_back(mk_row(0, 0, 32'h10000, 0, 32'h10000, 32'h10000, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(32'h7fffffff, 1, 0, 32'h7fffffff, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(32'h12345678, 32'h9abcdef0, 32'h0fedcba9,
                              32'hedcba987, 32'h65432100, 32'h13579bdf, 0, 0, 0, 0));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      send_pair(dir_rows[i].v, dir_rows[i].known, dir_rows[i].res);
      idle_gap();
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 3);
      for (int k = 0; k < 6; k++) v[k] = rand_comp(kind);
      if ($urandom_range(0, 49) == 0) begin
        for (int k = 0; k < 3; k++) v[k + 3 * $urandom_range(0, 1)] = '0;
      end else if ($urandom_range(0, 19) == 0) begin
        for (int k = 0; k < 3; k++) v[k+3] = $urandom_range(0, 1) ? v[k] : -v[k];
      end
      send_pair(v, 1'b0, none);
      idle_gap();
      if (n == N_RANDOM / 2) begin
        start_i <= 1'b0;
        while (pending_angles.size() != 0) @(posedge clk_i);
      end
    end
    start_i <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    if (error_count == 0) begin
      $display("vector_angle_degrees_top: match");
    end else begin
      $display("vector_angle_degrees_top: mismatch");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/vad_pkg.sv
rtl/vad_isqrt.sv
rtl/vector_angle_degrees_top.sv
tb/tb_vector_angle_degrees_top.sv
